>>> hw/rtl/pdd_pkg.sv
// Shared types and constants for the PI position drive with deadband.
// No dependencies; imported by every module of the block.
package pdd_pkg;

    localparam int POS_W   = 24;          // encoder / target width, signed
    localparam int ERR_W   = POS_W + 1;   // target minus position
    localparam int ACC_W   = POS_W + 2;   // integral before clamp
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 23;
    localparam int DUTY_W  = 8;
    localparam int PERR_W  = GAIN_W + 1 + ERR_W;   // 42
    localparam int PSUM_W  = GAIN_W + 1 + POS_W;   // 41
    localparam int FRAC_W  = 16;                   // Q0.16 gains
    localparam int CMAG_W  = PERR_W - FRAC_W;      // 26

    // Register map (index = paddr[4:2])
    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [2:0] REG_DEAD_ZONE   = 3'd2;
    localparam logic [2:0] REG_INTEG_LIMIT = 3'd3;
    localparam logic [2:0] REG_PWM_FLOOR   = 3'd4;
    localparam logic [2:0] REG_PWM_CEILING = 3'd5;

    // Reset values (50 rad^-1 and 2 rad^-1 scaled to counts, Q0.16)
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN   = 16'd5027;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN  = 16'd201;
    localparam logic [15:0]       RST_DEAD_ZONE   = 16'd130;
    localparam logic [LIM_W-1:0]  RST_INTEG_LIMIT = 23'd32595;
    localparam logic [DUTY_W-1:0] RST_PWM_FLOOR   = 8'd100;
    localparam logic [DUTY_W-1:0] RST_PWM_CEILING = 8'd255;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [15:0]       dead_zone;
        logic [LIM_W-1:0]  integ_limit;
        logic [DUTY_W-1:0] pwm_floor;
        logic [DUTY_W-1:0] pwm_ceiling;
    } pdd_cfg_t;

    typedef struct packed {
        logic                    mode;
        logic signed [POS_W-1:0] position_count;
        logic signed [POS_W-1:0] new_target;
    } pdd_item_t;

    // Error stage result
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [POS_W-1:0] acc;
        logic                    within_band;
    } pdd_err_t;

    typedef struct packed {
        logic [DUTY_W-1:0] forward_duty;
        logic [DUTY_W-1:0] reverse_duty;
        logic              within_band;
    } pdd_result_t;

endpackage

>>> hw/rtl/pdd_integ.sv
// Error and integral stage: holds target and accumulated error, registers
// error, clamped integral and deadband flag. Depends on pdd_pkg.
module pdd_integ
    import pdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pdd_cfg_t  cfg,
    input  pdd_item_t item,
    input  logic      load,
    output pdd_err_t  stage
);

    logic signed [POS_W-1:0] target_reg, target_next;
    logic signed [POS_W-1:0] sum_reg, sum_next;
    pdd_err_t                stage_reg, stage_next;

    logic signed [POS_W-1:0] base_tgt;
    logic signed [POS_W-1:0] base_sum;
    logic signed [ERR_W-1:0] err;
    logic        [ERR_W-1:0] mag;
    logic signed [ACC_W-1:0] acc_raw;
    logic signed [ACC_W-1:0] lim_pos;
    logic signed [ACC_W-1:0] lim_neg;
    logic signed [ACC_W-1:0] acc_clamp;
    logic                    outside;

    always_comb
    begin
        base_tgt = item.mode ? item.new_target : target_reg;
        base_sum = item.mode ? '0 : sum_reg;
        err      = ERR_W'(base_tgt) - ERR_W'(item.position_count);
        mag      = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        outside  = mag > ERR_W'(cfg.dead_zone);

        acc_raw  = ACC_W'(base_sum) + ACC_W'(err);
        lim_pos  = ACC_W'(signed'({1'b0, cfg.integ_limit}));
        lim_neg  = -lim_pos;
        if (acc_raw > lim_pos)
        begin
            acc_clamp = lim_pos;
        end
        else if (acc_raw < lim_neg)
        begin
            acc_clamp = lim_neg;
        end
        else
        begin
            acc_clamp = acc_raw;
        end

        target_next            = base_tgt;
        sum_next               = outside ? acc_clamp[POS_W-1:0] : '0;
        stage_next.err         = err;
        stage_next.acc         = acc_clamp[POS_W-1:0];
        stage_next.within_band = !outside;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            sum_reg    <= '0;
        end
        else if (load)
        begin
            target_reg <= target_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

>>> hw/rtl/pdd_drive.sv
// Drive stages: gain products, then sum, magnitude, shift and duty clamp.
// Depends on pdd_pkg.
module pdd_drive
    import pdd_pkg::*;
(
    input  logic        clk,
    input  pdd_cfg_t    cfg,
    input  pdd_err_t    stage,
    input  logic        load_prod,
    input  logic        load_out,
    output pdd_result_t result
);

    logic signed [PERR_W-1:0] perr_reg, perr_next;
    logic signed [PSUM_W-1:0] psum_reg, psum_next;
    logic                     band_reg;
    pdd_result_t              result_reg, result_next;

    logic signed [PERR_W-1:0] total;
    logic        [PERR_W-1:0] tmag;
    logic        [CMAG_W-1:0] cmag;
    logic        [DUTY_W-1:0] sat;
    logic        [DUTY_W-1:0] raised;
    logic        [DUTY_W-1:0] duty;
    logic                     neg;

    assign perr_next = $signed({1'b0, cfg.prop_gain}) * stage.err;
    assign psum_next = $signed({1'b0, cfg.integ_gain}) * stage.acc;

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            perr_reg <= perr_next;
            psum_reg <= psum_next;
            band_reg <= stage.within_band;
        end
    end

    always_comb
    begin
        // drive = -total; forward when total is negative
        total  = perr_reg + PERR_W'(psum_reg);
        neg    = total[PERR_W-1];
        tmag   = neg ? PERR_W'(-total) : PERR_W'(total);
        cmag   = tmag[PERR_W-1:FRAC_W];
        sat    = (|cmag[CMAG_W-1:DUTY_W]) ? {DUTY_W{1'b1}} : cmag[DUTY_W-1:0];
        raised = (sat < cfg.pwm_floor) ? cfg.pwm_floor : sat;
        duty   = (raised > cfg.pwm_ceiling) ? cfg.pwm_ceiling : raised;

        result_next.forward_duty = '0;
        result_next.reverse_duty = '0;
        result_next.within_band  = band_reg;
        if (!band_reg && (cmag != '0))
        begin
            if (neg)
            begin
                result_next.forward_duty = duty;
            end
            else
            begin
                result_next.reverse_duty = duty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> hw/rtl/pi_position_drive_deadband.sv
// Top level of the PI position drive with deadband and anti-windup.
// Depends on pdd_pkg, pdd_integ and pdd_drive.
//
//  channel   dir  fields (low bit first)
//  s_axis    in   tuser: mode | tdata: position_count[23:0], new_target[47:24]
//  m_axis    out  tdata: forward_duty[7:0], reverse_duty[15:8], within_band[16]
//  apb       cfg  six registers at byte offsets 0x00..0x14
//
// One beat per clock sustained while m_tready stays high. Four register levels:
// input register, error/integral stage (target and accumulated error update
// here), gain product stage, result register; each beat passes through them
// in that order before it is valid on m_axis.
// rst_n clears the valid flags, target and integral; cfg takes its reset values.
// A stalled result only holds the result register; the stages behind it keep
// filling until all four hold a beat, then s_tready drops.
module pi_position_drive_deadband
    import pdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // position_count[23:0], new_target[47:24]
    input  logic        s_tuser,   // mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // forward_duty[7:0], reverse_duty[15:8],
                                   // within_band[16], zero fill above
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pdd_cfg_t    cfg_reg, cfg_next;
    pdd_item_t   item_reg;
    pdd_err_t    err_stage;
    pdd_result_t result;

    logic v_in_reg,  v_in_next;
    logic v_err_reg, v_err_next;
    logic v_prd_reg, v_prd_next;
    logic v_out_reg, v_out_next;

    logic s_fire;
    logic ld_err;
    logic ld_prd;
    logic ld_out;
    logic cfg_wr;
    logic [2:0] reg_idx;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PROP_GAIN:   cfg_next.prop_gain   = pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  cfg_next.integ_gain  = pwdata[GAIN_W-1:0];
                REG_DEAD_ZONE:   cfg_next.dead_zone   = pwdata[15:0];
                REG_INTEG_LIMIT: cfg_next.integ_limit = pwdata[LIM_W-1:0];
                REG_PWM_FLOOR:   cfg_next.pwm_floor   = pwdata[DUTY_W-1:0];
                REG_PWM_CEILING: cfg_next.pwm_ceiling = pwdata[DUTY_W-1:0];
                default:         cfg_next = cfg_reg;   // unmapped: dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PROP_GAIN:   prdata = 32'(cfg_reg.prop_gain);
            REG_INTEG_GAIN:  prdata = 32'(cfg_reg.integ_gain);
            REG_DEAD_ZONE:   prdata = 32'(cfg_reg.dead_zone);
            REG_INTEG_LIMIT: prdata = 32'(cfg_reg.integ_limit);
            REG_PWM_FLOOR:   prdata = 32'(cfg_reg.pwm_floor);
            REG_PWM_CEILING: prdata = 32'(cfg_reg.pwm_ceiling);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain   <= RST_PROP_GAIN;
            cfg_reg.integ_gain  <= RST_INTEG_GAIN;
            cfg_reg.dead_zone   <= RST_DEAD_ZONE;
            cfg_reg.integ_limit <= RST_INTEG_LIMIT;
            cfg_reg.pwm_floor   <= RST_PWM_FLOOR;
            cfg_reg.pwm_ceiling <= RST_PWM_CEILING;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- pipeline flow control ----------------
    // Each stage loads when it has a beat and the one ahead is empty or
    // moving this cycle.
    assign ld_out   = v_prd_reg && (!v_out_reg || m_tready);
    assign ld_prd   = v_err_reg && (!v_prd_reg || ld_out);
    assign ld_err   = v_in_reg  && (!v_err_reg || ld_prd);
    assign s_tready = !v_in_reg || ld_err;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        v_in_next  = s_fire ? 1'b1 : (ld_err   ? 1'b0 : v_in_reg);
        v_err_next = ld_err ? 1'b1 : (ld_prd   ? 1'b0 : v_err_reg);
        v_prd_next = ld_prd ? 1'b1 : (ld_out   ? 1'b0 : v_prd_reg);
        v_out_next = ld_out ? 1'b1 : (m_tready ? 1'b0 : v_out_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg  <= 1'b0;
            v_err_reg <= 1'b0;
            v_prd_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            v_in_reg  <= v_in_next;
            v_err_reg <= v_err_next;
            v_prd_reg <= v_prd_next;
            v_out_reg <= v_out_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.mode           <= s_tuser;
            item_reg.position_count <= s_tdata[23:0];
            item_reg.new_target     <= s_tdata[47:24];
        end
    end

    // ---------------- datapath ----------------
    pdd_integ u_integ (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (item_reg),
        .load  (ld_err),
        .stage (err_stage)
    );

    pdd_drive u_drive (
        .clk       (clk),
        .cfg       (cfg_reg),
        .stage     (err_stage),
        .load_prod (ld_prd),
        .load_out  (ld_out),
        .result    (result)
    );

    assign m_tvalid = v_out_reg;
    assign m_tdata  = {7'b0, result.within_band, result.reverse_duty,
                       result.forward_duty};

    // ---------------- checks ----------------
    // Only one direction is ever driven.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[15:8] == 8'd0))
        else $error("both duty outputs nonzero");

    // Inside the deadband the motor is stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] == 16'd0))
        else $error("duty nonzero inside deadband");

    // With the result register empty nothing can hold the input back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A beat taken into the result register shows up as valid next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ld_out |=> m_tvalid)
        else $error("result load lost");

endmodule
